// File: rtl/calorimeter_adc_bank_unpacker_top_assert.svh
// Assertion macros shared by the unpacker RTL modules.
// No dependencies; included by modules that carry concurrent checks.
`ifndef CALORIMETER_ADC_BANK_UNPACKER_TOP_ASSERT_SVH
`define CALORIMETER_ADC_BANK_UNPACKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CABU_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cabu: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CABU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cabu: next-cycle check failed");

`endif

// File: rtl/cabu_pkg.sv
// Shared types and constants for the calorimeter ADC bank unpacker.
// No dependencies; used by cabu_front, cabu_fifo, cabu_back and the top level.
package cabu_pkg;

    // Bank coding formats
    localparam logic [1:0] FMT_NONE   = 2'd0;
    localparam logic [1:0] FMT_PLAIN  = 2'd1;
    localparam logic [1:0] FMT_PACKED = 2'd2;
    localparam logic [1:0] FMT_TAGGED = 2'd3;

    // Configuration register indexes
    localparam logic CFG_FORMAT_VERSION = 1'b0;
    localparam logic CFG_EXTRA_HEADER   = 1'b1;

    localparam logic [1:0] FORMAT_RESET = FMT_PACKED;

    // Packed format geometry
    localparam int WORD_BITS     = 32;
    localparam int LONG_BITS     = 12;
    localparam int SHORT_BITS    = 4;
    localparam int LONG_FIT_MAX  = WORD_BITS - LONG_BITS;
    localparam int LONG_BIAS     = 256;
    localparam int SHORT_BIAS    = 8;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Parser phase
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_EXTRA   = 3'd1,
        PH_SKIP    = 3'd2,
        PH_PATTERN = 3'd3,
        PH_DATA2   = 3'd4,
        PH_DATA3   = 3'd5
    } phase_t;

    // Kind of data word handed to the back end
    typedef enum logic [1:0] {
        K_PLAIN  = 2'd0,
        K_PACKED = 2'd1,
        K_TAGGED = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] word;
        logic [8:0]  card;
        logic        first;  // first packed data word after a pattern word
        logic        two;    // tagged word carries two entries
    } cmd_t;

    typedef struct packed {
        logic done;       // packed word fully decoded this cycle
        logic block_end;  // all card channels consumed
    } back_status_t;

endpackage

// File: rtl/cabu_front.sv
// Front end: accepts bank words, tracks block phase and issues data commands.
// Depends on cabu_pkg and the assertion macro header.
`include "calorimeter_adc_bank_unpacker_top_assert.svh"

module cabu_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [1:0]              format_version,
    input  logic                    extra_header,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [31:0]             s_data_word,
    input  logic                    s_bank_start,
    input  logic                    queue_full,
    input  cabu_pkg::back_status_t  status,
    output logic                    push_valid,
    output cabu_pkg::cmd_t          push_data,
    output logic [31:0]             pattern
);

    cabu_pkg::phase_t phase_reg, phase_next, eff_phase;
    logic [5:0]  skip_left_reg, skip_left_next, eff_skip, skip_dec, hdr_skip;
    logic [6:0]  entries_left_reg, entries_left_next, eff_entries, hdr_entries, ent_after;
    logic [8:0]  card_reg, card_next;
    logic [31:0] pattern_reg, pattern_next;
    logic        first_reg, first_next;
    logic        wait_reg, wait_next;
    logic        accept, fmt_data, cmd_valid, ent_two;

    function automatic cabu_pkg::phase_t after_skip(input logic [1:0] fmt,
                                                    input logic [6:0] ent);
        cabu_pkg::phase_t ph;
        if (fmt == cabu_pkg::FMT_TAGGED) begin
            ph = (ent != 7'd0) ? cabu_pkg::PH_DATA3 : cabu_pkg::PH_HEADER;
        end else begin
            ph = cabu_pkg::PH_PATTERN;
        end
        return ph;
    endfunction

    assign s_ready  = !wait_reg && !queue_full;
    assign accept   = s_valid && s_ready;
    assign fmt_data = (format_version == cabu_pkg::FMT_PACKED) ||
                      (format_version == cabu_pkg::FMT_TAGGED);
    assign pattern  = pattern_reg;

    // Bank start restarts the parser before the word is interpreted
    always_comb begin
        eff_phase   = phase_reg;
        eff_skip    = skip_left_reg;
        eff_entries = entries_left_reg;
        if (s_bank_start) begin
            eff_phase   = extra_header ? cabu_pkg::PH_EXTRA : cabu_pkg::PH_HEADER;
            eff_skip    = 6'd0;
            eff_entries = 7'd0;
        end
        hdr_skip    = 6'((8'(s_data_word[6:0]) + 8'd3) >> 2);
        hdr_entries = (format_version == cabu_pkg::FMT_TAGGED) ? s_data_word[13:7] : 7'd0;
        skip_dec    = (eff_skip != 6'd0) ? eff_skip - 6'd1 : 6'd0;
        ent_two     = eff_entries > 7'd1;
        ent_after   = eff_entries - (ent_two ? 7'd2 : 7'd1);
    end

    // Next state
    always_comb begin
        phase_next        = phase_reg;
        skip_left_next    = skip_left_reg;
        entries_left_next = entries_left_reg;
        card_next         = card_reg;
        pattern_next      = pattern_reg;
        first_next        = first_reg;
        wait_next         = wait_reg;
        if (accept) begin
            phase_next        = eff_phase;
            skip_left_next    = eff_skip;
            entries_left_next = eff_entries;
            if (eff_phase == cabu_pkg::PH_EXTRA) begin
                phase_next = cabu_pkg::PH_HEADER;
            end else if (fmt_data) begin
                unique case (eff_phase)
                    cabu_pkg::PH_HEADER: begin
                        card_next         = s_data_word[22:14];
                        skip_left_next    = hdr_skip;
                        entries_left_next = hdr_entries;
                        first_next        = 1'b1;
                        if (hdr_skip != 6'd0) begin
                            phase_next = cabu_pkg::PH_SKIP;
                        end else begin
                            phase_next = after_skip(format_version, hdr_entries);
                        end
                    end
                    cabu_pkg::PH_SKIP: begin
                        skip_left_next = skip_dec;
                        if (skip_dec == 6'd0) begin
                            phase_next = after_skip(format_version, eff_entries);
                        end
                    end
                    cabu_pkg::PH_PATTERN: begin
                        pattern_next = s_data_word;
                        first_next   = 1'b1;
                        phase_next   = cabu_pkg::PH_DATA2;
                    end
                    cabu_pkg::PH_DATA2: begin
                        // hold input until the back end has walked this word
                        first_next = 1'b0;
                        wait_next  = 1'b1;
                    end
                    cabu_pkg::PH_DATA3: begin
                        if (eff_entries == 7'd0) begin
                            phase_next = cabu_pkg::PH_HEADER;
                        end else begin
                            entries_left_next = ent_after;
                            if (ent_after == 7'd0) begin
                                phase_next = cabu_pkg::PH_HEADER;
                            end
                        end
                    end
                    default: begin
                        phase_next = cabu_pkg::PH_HEADER;
                    end
                endcase
            end
        end
        // packed word finished in the back end
        if (status.done) begin
            wait_next  = 1'b0;
            phase_next = status.block_end ? cabu_pkg::PH_HEADER : cabu_pkg::PH_DATA2;
        end
    end

    // Command to the back end
    always_comb begin
        cmd_valid       = 1'b0;
        push_data.kind  = cabu_pkg::K_PLAIN;
        push_data.word  = s_data_word;
        push_data.card  = card_reg;
        push_data.first = first_reg;
        push_data.two   = ent_two;
        if (eff_phase != cabu_pkg::PH_EXTRA) begin
            if (format_version == cabu_pkg::FMT_PLAIN) begin
                cmd_valid = 1'b1;
            end else if (fmt_data && eff_phase == cabu_pkg::PH_DATA2) begin
                cmd_valid      = 1'b1;
                push_data.kind = cabu_pkg::K_PACKED;
            end else if (fmt_data && eff_phase == cabu_pkg::PH_DATA3 &&
                         eff_entries != 7'd0) begin
                cmd_valid      = 1'b1;
                push_data.kind = cabu_pkg::K_TAGGED;
            end
        end
        push_valid = accept && cmd_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= cabu_pkg::PH_HEADER;
            skip_left_reg    <= 6'd0;
            entries_left_reg <= 7'd0;
            card_reg         <= 9'd0;
            pattern_reg      <= 32'd0;
            first_reg        <= 1'b0;
            wait_reg         <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            skip_left_reg    <= skip_left_next;
            entries_left_reg <= entries_left_next;
            card_reg         <= card_next;
            pattern_reg      <= pattern_next;
            first_reg        <= first_next;
            wait_reg         <= wait_next;
        end
    end

    `CABU_ASSERT_IMPL(a_wait_in_data2, aclk, aresetn, wait_reg, phase_reg == cabu_pkg::PH_DATA2)
    `CABU_ASSERT_NEXT(a_packed_push_waits, aclk, aresetn, push_valid && push_data.kind == cabu_pkg::K_PACKED, wait_reg)
    `CABU_ASSERT_IMPL(a_done_only_waiting, aclk, aresetn, status.done, wait_reg && !accept)

endmodule

// File: rtl/cabu_fifo.sv
// Short command queue between the front and back ends.
// Depends on cabu_pkg for the command type and depth.
module cabu_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    input  cabu_pkg::cmd_t  push_data,
    output logic            full,
    input  logic            pop_en,
    output logic            pop_valid,
    output cabu_pkg::cmd_t  pop_data
);

    cabu_pkg::cmd_t                     slot_reg [cabu_pkg::QUEUE_DEPTH];
    logic [cabu_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [cabu_pkg::QUEUE_CNT_W-1:0]   count_reg, count_next;
    logic                               do_push, do_pop;

    localparam logic [cabu_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        cabu_pkg::QUEUE_PTR_W'(cabu_pkg::QUEUE_DEPTH - 1);

    assign full      = count_reg == cabu_pkg::QUEUE_CNT_W'(cabu_pkg::QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_en && pop_valid;

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/cabu_back.sv
// Back end: decodes queued words into samples, one beat per cycle unless output stalls.
// Depends on cabu_pkg and the assertion macro header.
`include "calorimeter_adc_bank_unpacker_top_assert.svh"

module cabu_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_valid,
    input  cabu_pkg::cmd_t          q_data,
    output logic                    q_pop,
    input  logic [31:0]             pattern,
    output cabu_pkg::back_status_t  status,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [15:0]      m_adc_value,
    output logic [15:0]             m_channel_id,
    output logic [8:0]              m_card_code,
    output logic                    m_last_of_word
);

    // current item
    logic           cur_valid_reg, cur_valid_next;
    cabu_pkg::cmd_t cur_reg, cur_next;
    logic           half_reg, half_next;
    // packed format walk state
    logic [5:0]     ch_reg, ch_next, off_reg, off_next;
    logic           split_reg, split_next;
    logic [11:0]    partial_reg, partial_next;
    // output register
    logic           m_valid_reg, m_valid_next;
    logic [15:0]    adc_reg, chid_reg;
    logic [8:0]     card_reg;
    logic           last_reg;

    logic           adv, step, finish;
    logic [31:0]    w, sh_w;
    logic           pat_bit, pbit_n, ch_ok, off_ok, more, capture;
    logic [5:0]     off_g, offn, chn;
    logic [3:0]     low_shift;
    logic [11:0]    low_part, cap_part;
    logic [12:0]    split_sum;
    logic [15:0]    adc_packed, res_adc, res_chid;
    logic [15:0]    half_e;
    logic [8:0]     res_card;

    assign adv  = !m_valid_reg || m_ready;
    assign step = cur_valid_reg && adv;
    assign w    = cur_reg.word;

    // Packed format: one channel per step, with lookahead for the next one
    always_comb begin
        pat_bit   = pattern[ch_reg[4:0]];
        sh_w      = w >> off_reg[4:0];
        off_g     = (off_reg == 6'd0 || off_reg > 6'd11) ? 6'd4 : off_reg;
        low_shift = 4'(6'(cabu_pkg::LONG_BITS) - off_g);
        low_part  = 12'(w[11:0] << low_shift);
        split_sum = {1'b0, partial_reg} + {1'b0, low_part};
        if (split_reg) begin
            // long code finished from the tail of the previous word
            adc_packed = {3'b000, split_sum} - 16'(cabu_pkg::LONG_BIAS);
            offn       = off_g;
        end else if (!pat_bit) begin
            adc_packed = {12'd0, sh_w[3:0]} - 16'(cabu_pkg::SHORT_BIAS);
            offn       = off_reg + 6'(cabu_pkg::SHORT_BITS);
        end else begin
            adc_packed = {4'd0, sh_w[11:0]} - 16'(cabu_pkg::LONG_BIAS);
            offn       = off_reg + 6'(cabu_pkg::LONG_BITS);
        end
        chn      = ch_reg + 6'd1;
        ch_ok    = !chn[5];
        off_ok   = offn < 6'(cabu_pkg::WORD_BITS);
        pbit_n   = pattern[chn[4:0]];
        more     = ch_ok && off_ok && (!pbit_n || offn <= 6'(cabu_pkg::LONG_FIT_MAX));
        capture  = ch_ok && off_ok && pbit_n && !more;
        cap_part = 12'(w >> offn[4:0]);
    end

    // Result selection by item kind
    always_comb begin
        half_e   = half_reg ? w[31:16] : w[15:0];
        finish   = 1'b1;
        res_adc  = w[15:0];
        res_chid = w[31:16];
        res_card = 9'd0;
        unique case (cur_reg.kind)
            cabu_pkg::K_PLAIN: begin
                finish = 1'b1;
            end
            cabu_pkg::K_PACKED: begin
                finish   = !more;
                res_adc  = adc_packed;
                res_chid = {10'd0, ch_reg};
                res_card = cur_reg.card;
            end
            cabu_pkg::K_TAGGED: begin
                finish   = half_reg || !cur_reg.two;
                res_adc  = {6'd0, half_e[9:0]};
                res_chid = {10'd0, half_e[15:10]};
                res_card = cur_reg.card;
            end
            default: begin
                finish = 1'b1;
            end
        endcase
    end

    assign q_pop            = q_valid && (!cur_valid_reg || (step && finish));
    assign status.done      = step && finish && cur_reg.kind == cabu_pkg::K_PACKED;
    assign status.block_end = chn[5];

    // Next state
    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        half_next      = half_reg;
        ch_next        = ch_reg;
        off_next       = off_reg;
        split_next     = split_reg;
        partial_next   = partial_reg;
        m_valid_next   = m_valid_reg;
        if (step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (step && cur_reg.kind == cabu_pkg::K_PACKED) begin
            ch_next    = chn;
            split_next = 1'b0;
            off_next   = offn;
            if (!more) begin
                split_next = capture;
                off_next   = capture ? offn - 6'(cabu_pkg::LONG_FIT_MAX) : 6'd0;
                if (capture) begin
                    partial_next = cap_part;
                end
            end
        end
        if (step && cur_reg.kind == cabu_pkg::K_TAGGED) begin
            half_next = !finish;
        end
        if (step && finish) begin
            cur_valid_next = 1'b0;
        end
        // load the next queued item
        if (q_pop) begin
            cur_valid_next = 1'b1;
            cur_next       = q_data;
            half_next      = 1'b0;
            if (q_data.kind == cabu_pkg::K_PACKED && q_data.first) begin
                ch_next    = 6'd0;
                off_next   = 6'd0;
                split_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
            ch_reg        <= 6'd0;
            off_reg       <= 6'd0;
            split_reg     <= 1'b0;
            partial_reg   <= 12'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            half_reg      <= half_next;
            ch_reg        <= ch_next;
            off_reg       <= off_next;
            split_reg     <= split_next;
            partial_reg   <= partial_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (step) begin
            adc_reg  <= res_adc;
            chid_reg <= res_chid;
            card_reg <= res_card;
            last_reg <= finish;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_adc_value    = $signed(adc_reg);
    assign m_channel_id   = chid_reg;
    assign m_card_code    = card_reg;
    assign m_last_of_word = last_reg;

    `CABU_ASSERT_IMPL(a_packed_channel_range, aclk, aresetn, step && cur_reg.kind == cabu_pkg::K_PACKED, !ch_reg[5])
    `CABU_ASSERT_IMPL(a_capture_offset, aclk, aresetn, step && cur_reg.kind == cabu_pkg::K_PACKED && capture, offn > 6'd20 && offn < 6'd32)
    `CABU_ASSERT_IMPL(a_pop_slot_free, aclk, aresetn, q_pop, !cur_valid_reg || (step && finish))
    `CABU_ASSERT_NEXT(a_step_gives_beat, aclk, aresetn, step, m_valid)

endmodule

// File: rtl/calorimeter_adc_bank_unpacker_top.sv
// Calorimeter ADC bank unpacker: takes 32-bit bank words and emits decoded
// ADC samples in plain, pattern-packed or channel-tagged coding. Extra header,
// block header, trigger skip and pattern words give no sample. A plain word
// or a tagged entry leaves at one sample per cycle while the output is taken.
// A packed data word holds the input: the input side waits until the decoder
// has walked all channels of that word, one channel per cycle while the output
// is taken, because the next word's meaning depends on where the card block
// ends. A two-entry command queue and an output register let input and output
// stall independently.
// Configuration registers: index 0 format_version (reset 2), index 1
// extra_header (reset 0); write them only while the block is idle.
// Depends on cabu_pkg, cabu_front, cabu_fifo and cabu_back.
module calorimeter_adc_bank_unpacker_top (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write port
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [1:0]         cfg_data,
    // bank words in
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_data_word,
    input  logic               s_bank_start,
    // samples out
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_adc_value,
    output logic [15:0]        m_channel_id,
    output logic [8:0]         m_card_code,
    output logic               m_last_of_word
);

    logic [1:0]             format_version_reg, format_version_next;
    logic                   extra_header_reg, extra_header_next;
    logic                   queue_full, push_valid, q_valid, q_pop;
    cabu_pkg::cmd_t         push_data, q_data;
    cabu_pkg::back_status_t status;
    logic [31:0]            pattern;

    // Configuration register decode
    always_comb begin
        format_version_next = format_version_reg;
        extra_header_next   = extra_header_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                cabu_pkg::CFG_FORMAT_VERSION: format_version_next = cfg_data;
                cabu_pkg::CFG_EXTRA_HEADER:   extra_header_next   = cfg_data[0];
                default: begin
                    format_version_next = format_version_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_version_reg <= cabu_pkg::FORMAT_RESET;
            extra_header_reg   <= 1'b0;
        end else begin
            format_version_reg <= format_version_next;
            extra_header_reg   <= extra_header_next;
        end
    end

    cabu_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .format_version (format_version_reg),
        .extra_header   (extra_header_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_word    (s_data_word),
        .s_bank_start   (s_bank_start),
        .queue_full     (queue_full),
        .status         (status),
        .push_valid     (push_valid),
        .push_data      (push_data),
        .pattern        (pattern)
    );

    cabu_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (queue_full),
        .pop_en     (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    cabu_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .pattern        (pattern),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_adc_value    (m_adc_value),
        .m_channel_id   (m_channel_id),
        .m_card_code    (m_card_code),
        .m_last_of_word (m_last_of_word)
    );

endmodule

// File: tb/tb.sv
// Self-checking testbench for calorimeter_adc_bank_unpacker_top: directed bank words from a
// table, then random banks in every coding, checked against a cycle-free unpacking model.
// Depends on cabu_pkg and the unpacker RTL.
module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_PER_WORD   = 8;
    localparam int DIR_ROWS       = 30;
    localparam int PHASES         = 7;

    // Coding and register index codes used by the table and the model
    localparam logic [1:0] FMT_NONE           = cabu_pkg::FMT_NONE;
    localparam logic [1:0] FMT_PLAIN          = cabu_pkg::FMT_PLAIN;
    localparam logic [1:0] FMT_PACKED         = cabu_pkg::FMT_PACKED;
    localparam logic [1:0] FMT_TAGGED         = cabu_pkg::FMT_TAGGED;
    localparam logic       CFG_FORMAT_VERSION = cabu_pkg::CFG_FORMAT_VERSION;
    localparam logic       CFG_EXTRA_HEADER   = cabu_pkg::CFG_EXTRA_HEADER;

    // One decoded sample as it leaves the block
    typedef struct packed {
        logic signed [15:0] adc;
        logic [15:0]        chan;
        logic [8:0]         card;
        logic               last;
    } adc_sample_t;

    // Directed stimulus: either a register write or one bank word; a typed row
    // carries its own expectation (at most one sample)
    typedef struct packed {
        logic               is_cfg;
        logic               cfg_idx;
        logic [1:0]         cfg_val;
        logic [31:0]        word;
        logic               bstart;
        logic               typed;
        logic               has_sample;
        logic signed [15:0] adc;
        logic [15:0]        chan;
        logic [8:0]         card;
    } stim_row_t;

    // Random phases: coding, extra header flag, number of bank words
    localparam logic [1:0] FMT_PLAN [0:PHASES-1] =
        '{FMT_PACKED, FMT_TAGGED, FMT_PLAIN, FMT_PACKED, FMT_NONE, FMT_TAGGED, FMT_PACKED};
    localparam logic EXTRA_PLAN [0:PHASES-1] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    localparam int PHASE_WORDS [0:PHASES-1] = '{60, 60, 45, 60, 12, 55, 60};

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic               cfg_index;
    logic [1:0]         cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic [31:0]        s_data_word;
    logic               s_bank_start;
    logic               m_valid;
    logic               rx_ready = 1'b0;
    logic signed [15:0] m_adc_value;
    logic [15:0]        m_channel_id;
    logic [8:0]         m_card_code;
    logic               m_last_of_word;

    // Unpacking model state (reset values)
    logic [1:0]        pr_fmt     = cabu_pkg::FORMAT_RESET;
    logic              pr_extra   = 1'b0;
    cabu_pkg::phase_t  pr_phase   = cabu_pkg::PH_HEADER;
    logic [5:0]        pr_skip    = '0;
    logic [31:0]       pr_pattern = '0;
    logic [5:0]        pr_chan    = '0;
    logic [5:0]        pr_offset  = '0;
    logic [11:0]       pr_partial = '0;
    logic              pr_split   = 1'b0;
    logic [6:0]        pr_entries = '0;
    logic [8:0]        pr_card    = '0;

    adc_sample_t word_samples[$];
    adc_sample_t pending_samples[$];
    adc_sample_t want;
    adc_sample_t got;

    int mismatches  = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int bank_left   = 0;
    int rx_left     = 0;
    bit gaps_on     = 1'b1;

    stim_row_t dir_rows [0:DIR_ROWS-1] = '{
        // packed coding: header with every control bit set, all-short pattern, 32 channels
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'hFFFF_FF80, 1'b1, 1'b1, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'h1234_5678, 1'b0, 1'b0, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'h89AB_CDEF, 1'b0, 1'b0, 1'b0, 16'sd0, 16'h0, 9'h0},
        // header with two trigger words, all-long pattern, codes split across words
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'h0000_C005, 1'b0, 1'b1, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'hDEAD_BEEF, 1'b0, 1'b1, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'h0000_0FFF, 1'b0, 1'b0, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 16'sd0, 16'h0, 9'h0},
        // truncated block: new bank drops the pending split code
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 16'sd0, 16'h0, 9'h0},
        // extra header word swallowed at bank start
        '{1'b1, CFG_EXTRA_HEADER,   2'd1,     32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 16'sd0, 16'h0, 9'h0},
        // plain coding: ADC extremes, id extremes
        '{1'b1, CFG_FORMAT_VERSION, FMT_PLAIN, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'h0000_7FFF, 1'b0, 1'b1, 1'b1, 16'sd32767, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'hFFFF_8000, 1'b0, 1'b1, 1'b1, 16'sh8000, 16'hFFFF, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'h1234_5678, 1'b1, 1'b1, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'hABCD_0001, 1'b0, 1'b1, 1'b1, 16'sd1, 16'hABCD, 9'h0},
        // tagged coding: odd entry count, then an empty block with one trigger word
        '{1'b1, CFG_FORMAT_VERSION, FMT_TAGGED, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b1, CFG_EXTRA_HEADER,   2'd0,     32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'h0055_4180, 1'b1, 1'b1, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'hFFFF_0000, 1'b0, 1'b0, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 16'sd1023, 16'h3F,
          9'h155},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'h0000_4004, 1'b0, 1'b1, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'hAAAA_5555, 1'b0, 1'b1, 1'b0, 16'sd0, 16'h0, 9'h0},
        // unsupported coding ignores everything
        '{1'b1, CFG_FORMAT_VERSION, FMT_NONE, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'sd0, 16'h0, 9'h0},
        '{1'b0, CFG_FORMAT_VERSION, FMT_NONE, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 16'sd0, 16'h0, 9'h0}
    };

    calorimeter_adc_bank_unpacker_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_word    (s_data_word),
        .s_bank_start   (s_bank_start),
        .m_valid        (m_valid),
        .m_ready        (rx_ready),
        .m_adc_value    (m_adc_value),
        .m_channel_id   (m_channel_id),
        .m_card_code    (m_card_code),
        .m_last_of_word (m_last_of_word)
    );

    always #2 aclk = ~aclk;

    // ---------------- unpacking model ----------------

    // Keeps at most eight samples per word, as the block does
    function automatic void add_sample(input logic [15:0] adc, input logic [15:0] chan,
                                       input logic [8:0] card);
        adc_sample_t s;
        s.adc  = adc;
        s.chan = chan;
        s.card = card;
        s.last = 1'b0;
        if (word_samples.size() < MAX_PER_WORD) word_samples.insert(word_samples.size(), s);
    endfunction

    // Trigger skip done: tagged blocks go to entries (or straight on), packed to pattern
    function automatic void end_of_skip();
        if (pr_fmt == FMT_TAGGED)
            pr_phase = (pr_entries != 0) ? cabu_pkg::PH_DATA3 : cabu_pkg::PH_HEADER;
        else pr_phase = cabu_pkg::PH_PATTERN;
    endfunction

    function automatic void decode_block_header(input logic [31:0] w);
        pr_card    = w[22:14];
        pr_skip    = 6'((int'(w[6:0]) + 3) >> 2);
        pr_split   = 1'b0;
        pr_offset  = '0;
        pr_chan    = '0;
        pr_entries = (pr_fmt == FMT_TAGGED) ? w[13:7] : 7'd0;
        if (pr_skip != 0) pr_phase = cabu_pkg::PH_SKIP;
        else end_of_skip();
    endfunction

    // Packed data word: finish a split long code, then walk channels LSB first
    function automatic void unpack_packed(input logic [31:0] w);
        int          off;
        logic [31:0] hi_bits;
        off = pr_offset;
        if (pr_split) begin
            if (off == 0 || off > 11) off = 4;
            hi_bits = w << (12 - off);
            add_sample(16'(int'(pr_partial) + int'(hi_bits[11:0]) - 256), 16'(pr_chan), pr_card);
            pr_chan++;
            pr_split = 1'b0;
        end else begin
            off = 0;
        end
        while (pr_chan < 32 && off < 32) begin
            if (!pr_pattern[pr_chan]) begin
                add_sample(16'(int'((w >> off) & 32'hF) - 8), 16'(pr_chan), pr_card);
                off += 4;
                pr_chan++;
            end else if (off + 12 <= 32) begin
                add_sample(16'(int'((w >> off) & 32'hFFF) - 256), 16'(pr_chan), pr_card);
                off += 12;
                pr_chan++;
            end else begin
                pr_partial = 12'(w >> off);
                pr_split   = 1'b1;
                off        = off - 20;
                break;
            end
        end
        if (pr_split) begin
            pr_offset = 6'(off);
        end else begin
            pr_offset = '0;
            if (pr_chan >= 32) pr_phase = cabu_pkg::PH_HEADER;
        end
    endfunction

    // Tagged data word: up to two entries, low half first
    function automatic void unpack_tagged(input logic [31:0] w);
        int          h;
        logic [15:0] e;
        for (h = 0; h < 2 && pr_entries != 0; h++) begin
            e = 16'(w >> (16 * h));
            add_sample(16'(e[9:0]), 16'(e[15:10]), pr_card);
            pr_entries--;
        end
        if (pr_entries == 0) pr_phase = cabu_pkg::PH_HEADER;
    endfunction

    // Samples caused by one accepted bank word, left in word_samples
    function automatic void unpack_word(input logic [31:0] w, input logic bs);
        word_samples.delete();
        if (bs) begin
            pr_phase   = pr_extra ? cabu_pkg::PH_EXTRA : cabu_pkg::PH_HEADER;
            pr_skip    = '0;
            pr_chan    = '0;
            pr_offset  = '0;
            pr_split   = 1'b0;
            pr_entries = '0;
        end
        if (pr_phase == cabu_pkg::PH_EXTRA) begin
            pr_phase = cabu_pkg::PH_HEADER;
        end else if (pr_fmt == FMT_PLAIN) begin
            add_sample(w[15:0], w[31:16], 9'd0);
        end else if (pr_fmt != FMT_NONE) begin
            case (pr_phase)
                cabu_pkg::PH_HEADER: decode_block_header(w);
                cabu_pkg::PH_SKIP: begin
                    if (pr_skip != 0) pr_skip--;
                    if (pr_skip == 0) end_of_skip();
                end
                cabu_pkg::PH_PATTERN: begin
                    pr_pattern = w;
                    pr_chan    = '0;
                    pr_offset  = '0;
                    pr_split   = 1'b0;
                    pr_phase   = cabu_pkg::PH_DATA2;
                end
                cabu_pkg::PH_DATA2: unpack_packed(w);
                cabu_pkg::PH_DATA3: unpack_tagged(w);
                default:  pr_phase = cabu_pkg::PH_HEADER;
            endcase
        end
    endfunction

    // Queue the model's samples, marking the last one of the word
    function automatic void expect_samples();
        int          i;
        adc_sample_t s;
        for (i = 0; i < word_samples.size(); i++) begin
            s      = word_samples[i];
            s.last = (i == word_samples.size() - 1);
            pending_samples.insert(pending_samples.size(), s);
        end
    endfunction

    // ---------------- random bank generation ----------------

    // Bank boundaries; an open card block usually runs to its end first
    function automatic logic start_of_bank();
        logic bs;
        bs = 1'b0;
        if (bank_left == 0 && pr_fmt >= FMT_PACKED && pr_phase != cabu_pkg::PH_HEADER &&
            $urandom_range(0, 3) != 0)
            bank_left = 1;
        if (bank_left == 0) begin
            bs = 1'b1;
            bank_left = (pr_fmt == FMT_PLAIN) ? $urandom_range(1, 10) : $urandom_range(6, 40);
        end else if ($urandom_range(0, 49) == 0) begin
            bs = 1'b1;  // truncates the current block
        end
        bank_left--;
        return bs;
    endfunction

    // Well-formed word for where the parser stands, with some noise
    function automatic logic [31:0] pick_word(input logic bs);
        cabu_pkg::phase_t ph;
        logic [31:0]      w;
        int               trig_len;
        int               n_entries;
        logic [8:0]       card;
        ph = bs ? (pr_extra ? cabu_pkg::PH_EXTRA : cabu_pkg::PH_HEADER) : pr_phase;
        w  = $urandom;
        if ($urandom_range(0, 15) == 0 || ph == cabu_pkg::PH_EXTRA ||
            pr_fmt == FMT_PLAIN || pr_fmt == FMT_NONE)
            return w;
        case (ph)
            cabu_pkg::PH_HEADER: begin
                trig_len  = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 127)
                                                         : $urandom_range(0, 9);
                n_entries = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 127)
                                                         : $urandom_range(0, 9);
                card = 9'($urandom);
                w = (w & 32'hFF80_0000) | (32'(card) << 14) | (32'(n_entries) << 7)
                    | 32'(trig_len);
            end
            cabu_pkg::PH_PATTERN: begin
                case ($urandom_range(0, 4))
                    0: w = '0;
                    1: w = '1;
                    2: w = $urandom & $urandom;
                    3: w = $urandom | $urandom;
                    default: w = $urandom;
                endcase
            end
            default: begin
                case ($urandom_range(0, 7))
                    0: w = '0;
                    1: w = '1;
                    default: w = $urandom;
                endcase
            end
        endcase
        return w;
    endfunction

    // ---------------- drivers ----------------

    // Present one beat, in bursts with random gaps; returns on acceptance
    task automatic send_item(input logic [31:0] w, input logic bs);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_valid      <= 1'b1;
        s_data_word  <= w;
        s_bank_start <= bs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    // Idle the input and let every expected sample and in-flight word drain
    task automatic wait_drained();
        s_valid   <= 1'b0;
        burst_left = 0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic idx, input logic [1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_FORMAT_VERSION) pr_fmt = val;
        else pr_extra = val[0];
        @(posedge aclk);
    endtask

    // Receiver: segments of stall and take, now and then a long free stretch
    always @(posedge aclk) begin
        if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else begin
            case ($urandom_range(0, 7))
                0: begin
                    rx_ready <= 1'b1;
                    rx_left  <= $urandom_range(40, 120);
                end
                1, 2: begin
                    rx_ready <= 1'b0;
                    rx_left  <= $urandom_range(0, 11);
                end
                default: begin
                    rx_ready <= 1'b1;
                    rx_left  <= $urandom_range(0, 5);
                end
            endcase
        end
    end

    // Output checker: each sample beat against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && rx_ready) begin
            got.adc  = m_adc_value;
            got.chan = m_channel_id;
            got.card = m_card_code;
            got.last = m_last_of_word;
            if (pending_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sample: adc %0d ch 0x%h card 0x%h last %0b",
                             got.adc, got.chan, got.card, got.last);
            end else begin
                want = pending_samples.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sample mismatch: exp adc %0d ch 0x%h card 0x%h last %0b, %s",
                                 want.adc, want.chan, want.card, want.last,
                                 $sformatf("got adc %0d ch 0x%h card 0x%h last %0b",
                                           got.adc, got.chan, got.card, got.last));
                end
            end
        end
    end

    // Watchdog: too long without any beat on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && rx_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        stim_row_t   row;
        adc_sample_t s;
        logic [31:0] w;
        logic        bs;
        int          r;
        int          p;
        int          k;

        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= CFG_FORMAT_VERSION;
        cfg_data     <= cabu_pkg::FORMAT_RESET;
        s_valid      <= 1'b0;
        s_data_word  <= '0;
        s_bank_start <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (r = 0; r < DIR_ROWS; r++) begin
            row = dir_rows[r];
            if (row.is_cfg) begin
                wait_drained();
                reg_write(row.cfg_idx, row.cfg_val);
            end else begin
                send_item(row.word, row.bstart);
                unpack_word(row.word, row.bstart);
                if (!row.typed) begin
                    expect_samples();
                end else if (row.has_sample) begin
                    s.adc  = row.adc;
                    s.chan = row.chan;
                    s.card = row.card;
                    s.last = 1'b1;
                    pending_samples.insert(pending_samples.size(), s);
                end
            end
        end

        // random banks; a phase may open inside the previous phase's bank
        for (p = 0; p < PHASES; p++) begin
            wait_drained();
            reg_write(CFG_FORMAT_VERSION, FMT_PLAN[p]);
            reg_write(CFG_EXTRA_HEADER, {1'b0, EXTRA_PLAN[p]});
            gaps_on = (p != 3);
            for (k = 0; k < PHASE_WORDS[p]; k++) begin
                bs = start_of_bank();
                w  = pick_word(bs);
                send_item(w, bs);
                unpack_word(w, bs);
                expect_samples();
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
